@@ sv/fli_pkg.sv @@
// Shared types and constants for the Faddeev-LeVerrier inverse block.
package fli_pkg;
  localparam int unsigned ValW = 64;
  localparam logic signed [63:0] SatMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SatMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] OneQ32 = 64'sh0000_0001_0000_0000;

  typedef enum logic {
    KindInverse = 1'b0,
    KindCoef    = 1'b1
  } result_kind_e;

  // Saturating 64-bit add.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SatMin : SatMax;
    end
    return s[63:0];
  endfunction
endpackage

@@ sv/fli_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module fli_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 49
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/fli_div.sv @@
// Restoring divider: 128-bit dividend by 64-bit divisor, one quotient bit per cycle.
module fli_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [63:0]  den_i,
  output logic         done_o,
  output logic [127:0] quot_o,
  output logic [63:0]  rem_o
);
  logic [7:0]   cnt_q;
  logic         busy_q;
  logic [127:0] q_q;
  logic [64:0]  r_q;
  logic [63:0]  d_q;
  logic [64:0]  r_sh;

  assign r_sh = {r_q[63:0], q_q[127]};

  // One shift-subtract step per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 8'd128;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 8'd1;
        if (cnt_q == 8'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      if (r_sh >= {1'b0, d_q}) begin
        r_q <= r_sh - {1'b0, d_q};
        q_q <= {q_q[126:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[126:0], 1'b0};
      end
    end
  end

  assign quot_o = q_q;
  assign rem_o  = r_q[63:0];
endmodule

@@ sv/faddeev_leverrier_inverse.sv @@
// Top level: Faddeev-LeVerrier inverse and characteristic polynomial of a loaded matrix.
//
//   channel | direction | handshake           | payload
//   elem    | in        | elem_valid_i/stall_o| element_value_i
//   result  | out       | res_valid_o/stall_i | kind,row,col,value,singular,last
//   config  | in        | cfg_we_i            | cfg_wdata_i (matrix_size)
//
// Loading takes one cycle per element, then B = I is written. Each 32x64 product is formed
// as two partial products on the low and high 32-bit halves of B and accumulated into D;
// each step k then computes its coefficient on the serial divider and, but for the last
// step, updates B. Each inverse entry is computed with its own divide; the coefficients
// follow one a cycle while the result channel is not stalled. Reset clears only control
// state. The input stalls from the last element until the final result.
module faddeev_leverrier_inverse
  import fli_pkg::*;
#(
  parameter int unsigned MAX_ORDER       = 7,
  parameter int unsigned INPUT_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               elem_valid_i,
  output logic               elem_stall_o,
  input  logic signed [31:0] element_value_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic               result_kind_o,
  output logic [2:0]         row_index_o,
  output logic [2:0]         col_index_o,
  output logic signed [63:0] result_value_o,
  output logic               singular_flag_o,
  output logic               last_result_o
);
  localparam int unsigned Depth = MAX_ORDER * MAX_ORDER;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FB = INPUT_FRAC_BITS;

  typedef enum logic [3:0] {
    StLoad, StInit, StMac, StMacWait, StStore, StTrace, StCoefDiv, StCoefWait,
    StUpdate, StUpdWr, StOutRd, StOutDiv, StOutWait, StOut
  } state_e;

  state_e state_q;
  logic [2:0]    size_q;
  logic [AW-1:0] lcnt_q;
  logic [2:0]    n;
  logic [2:0]    k_q, i_q, j_q, h_q;
  logic signed [127:0] acc_q;
  logic signed [63:0]  trace_q, cn_q;
  logic signed [63:0]  coef_q [MAX_ORDER];
  logic                sing_q;
  logic                phase_q;

  // Effective order.
  always_comb begin
    n = (size_q == 3'd0) ? 3'd1 : size_q;
    if (32'(n) > MAX_ORDER) n = 3'(MAX_ORDER);
  end

  function automatic logic [AW-1:0] idx(input logic [2:0] r, input logic [2:0] c);
    return AW'(32'(r) * MAX_ORDER + 32'(c));
  endfunction

  // A is stored in row-major order of the order it was loaded with.
  function automatic logic [AW-1:0] idx_a(input logic [2:0] r, input logic [2:0] c,
                                          input logic [2:0] ord);
    return AW'(32'(r) * 32'(ord) + 32'(c));
  endfunction

  // Memories: A, B and D.
  logic          a_we, b_we, d_we;
  logic [AW-1:0] a_wa, b_wa, d_wa, a_ra, b_ra, d_ra;
  logic [31:0]   a_wd, a_rd;
  logic [63:0]   b_wd, d_wd, b_rd, d_rd;

  fli_ram #(.Width(32), .Depth(Depth)) u_a (.clk_i, .we_i(a_we), .waddr_i(a_wa),
    .wdata_i(a_wd), .raddr_i(a_ra), .rdata_o(a_rd));
  fli_ram #(.Width(64), .Depth(Depth)) u_b (.clk_i, .we_i(b_we), .waddr_i(b_wa),
    .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));
  fli_ram #(.Width(64), .Depth(Depth)) u_d (.clk_i, .we_i(d_we), .waddr_i(d_wa),
    .wdata_i(d_wd), .raddr_i(d_ra), .rdata_o(d_rd));

  // Divider shared by coefficients and inverse entries.
  logic         div_start, div_done;
  logic [127:0] div_num, div_q;
  logic [63:0]  div_den, div_r;
  fli_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r));

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Partial products of A and B read data, registered before the accumulate.
  // The low half of B is taken first, the high half in the following cycle.
  logic signed [95:0] prod_q;
  logic               lo_v_q, hi_v_q;
  logic signed [64:0] pp_lo;
  logic signed [63:0] pp_hi;
  always_comb begin
    pp_lo = $signed({{33{a_rd[31]}}, a_rd}) * $signed({33'd0, b_rd[31:0]});
    pp_hi = $signed({{32{a_rd[31]}}, a_rd}) * $signed({{32{b_rd[63]}}, b_rd[63:32]});
  end

  // Rounding and saturation of an accumulated product.
  logic signed [127:0] rnd;
  logic signed [127:0] shf;
  logic signed [63:0]  d_val;
  always_comb begin
    rnd = acc_q + (128'sd1 <<< (FB - 1));
    shf = rnd >>> FB;
    if (shf > 128'(SatMax)) d_val = SatMax;
    else if (shf < $signed({{64{1'b1}}, SatMin})) d_val = SatMin;
    else d_val = shf[63:0];
  end

  // Coefficient from the divider result.
  logic [63:0]        coef_mag;
  logic signed [63:0] coef_val;
  always_comb begin
    coef_mag = div_q[63:0];
    if (!trace_q[63] && trace_q != 0) begin
      coef_val = (div_q[127:64] != 0 || coef_mag > 64'h8000_0000_0000_0000) ? SatMin
               : 64'(-coef_mag);
    end else begin
      coef_val = (div_q[127:64] != 0 || coef_mag[63]) ? SatMax : coef_mag;
    end
  end

  // Inverse entry from the divider result.
  logic               inv_neg;
  logic [63:0]        md, lim;
  logic [128:0]       qr;
  logic signed [63:0] inv_val;
  logic               b_zero_q;
  logic               b_neg_q;
  always_comb begin
    md = mag(cn_q);
    inv_neg = (!b_neg_q && !cn_q[63]) || (b_neg_q && cn_q[63]);
    qr = {1'b0, div_q} + ((div_r >= md - div_r) ? 129'd1 : 129'd0);
    lim = inv_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (qr[128:64] != 0 || qr[63:0] > lim) qr = {65'd0, lim};
    if (b_zero_q) inv_val = '0;
    else inv_val = inv_neg ? 64'(-qr[63:0]) : qr[63:0];
  end

  logic in_acc;
  assign elem_stall_o = (state_q != StLoad);
  assign in_acc = elem_valid_i && !elem_stall_o;

  always_comb begin
    a_we = in_acc;
    a_wa = lcnt_q;
    a_wd = element_value_i;
    a_ra = idx_a(i_q, h_q, n);
    b_ra = (state_q == StOutRd) ? idx(i_q, j_q) : idx(h_q, j_q);
    d_ra = idx(i_q, j_q);
    b_we = 1'b0; b_wa = idx(i_q, j_q); b_wd = '0;
    d_we = 1'b0; d_wa = idx(i_q, j_q); d_wd = d_val;
    div_start = 1'b0; div_num = '0; div_den = '0;
    case (state_q)
      StInit: begin
        b_we = 1'b1;
        b_wd = (i_q == j_q) ? OneQ32 : '0;
      end
      StStore: d_we = 1'b1;
      StCoefDiv: begin
        div_start = 1'b1;
        div_num = {64'd0, mag(trace_q) + 64'(k_q >> 1)};
        div_den = 64'(k_q);
      end
      StUpdWr: begin
        b_we = 1'b1;
        b_wd = (i_q == j_q) ? sat_add(d_rd, coef_q[k_q - 3'd1]) : d_rd;
      end
      StOutDiv: begin
        div_start = 1'b1;
        div_num = {32'd0, mag(b_rd), 32'd0};
        div_den = mag(cn_q);
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      size_q <= 3'd7;
      lcnt_q <= '0;
      res_valid_o <= 1'b0;
      k_q <= '0; i_q <= '0; j_q <= '0; h_q <= '0;
      lo_v_q <= 1'b0;
      hi_v_q <= 1'b0;
      phase_q <= 1'b0;
      trace_q <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
        lcnt_q <= '0;
      end
      lo_v_q <= 1'b0;
      hi_v_q <= 1'b0;
      case (state_q)
        StLoad: if (in_acc) begin
          if (32'(lcnt_q) + 1 >= 32'(n) * 32'(n)) begin
            lcnt_q <= '0;
            state_q <= StInit;
            i_q <= '0; j_q <= '0; k_q <= 3'd1;
          end else begin
            lcnt_q <= lcnt_q + AW'(1);
          end
        end
        StInit: begin
          if (j_q == n - 3'd1) begin
            j_q <= '0;
            if (i_q == n - 3'd1) begin
              i_q <= '0; h_q <= '0; acc_q <= '0;
              state_q <= StMac;
            end else i_q <= i_q + 3'd1;
          end else j_q <= j_q + 3'd1;
        end
        StMac: begin
          // Reads issued for h_q; data is valid in the second phase and the cycle after.
          phase_q <= 1'b1;
          if (phase_q) begin
            prod_q <= 96'(pp_lo);
            lo_v_q <= 1'b1;
            phase_q <= 1'b0;
            if (h_q == n - 3'd1) state_q <= StMacWait;
            else h_q <= h_q + 3'd1;
          end
        end
        StMacWait: if (!lo_v_q && !hi_v_q) state_q <= StStore;
        StStore: begin
          if (i_q == j_q) trace_q <= sat_add(trace_q, d_val);
          h_q <= '0;
          if (j_q == n - 3'd1) begin
            j_q <= '0;
            if (i_q == n - 3'd1) begin
              i_q <= '0;
              state_q <= StTrace;
            end else i_q <= i_q + 3'd1;
          end else j_q <= j_q + 3'd1;
          if (!(j_q == n - 3'd1 && i_q == n - 3'd1)) state_q <= StMac;
          acc_q <= '0;
        end
        StTrace: state_q <= StCoefDiv;
        StCoefDiv: state_q <= StCoefWait;
        StCoefWait: if (div_done) begin
          coef_q[k_q - 3'd1] <= coef_val;
          trace_q <= '0;
          if (k_q == n) begin
            cn_q <= coef_val;
            sing_q <= (coef_val == 0);
            state_q <= StOutRd;
            i_q <= '0; j_q <= '0; phase_q <= 1'b0;
          end else begin
            state_q <= StUpdate;
            phase_q <= 1'b0;
          end
        end
        StUpdate: state_q <= StUpdWr;
        StUpdWr: begin
          if (j_q == n - 3'd1) begin
            j_q <= '0;
            if (i_q == n - 3'd1) begin
              i_q <= '0; h_q <= '0; acc_q <= '0;
              k_q <= k_q + 3'd1;
              state_q <= StMac;
            end else begin
              i_q <= i_q + 3'd1;
              state_q <= StUpdate;
            end
          end else begin
            j_q <= j_q + 3'd1;
            state_q <= StUpdate;
          end
        end
        StOutRd: state_q <= StOutDiv;
        StOutDiv: begin
          b_zero_q <= (b_rd == 0) || sing_q;
          b_neg_q <= b_rd[63];
          state_q <= StOutWait;
        end
        StOutWait: if (div_done) begin
          res_valid_o <= 1'b1;
          result_kind_o <= KindInverse;
          row_index_o <= i_q; col_index_o <= j_q;
          result_value_o <= inv_val;
          singular_flag_o <= sing_q;
          last_result_o <= 1'b0;
          state_q <= StOut;
        end
        StOut: if (!res_stall_i) begin
          res_valid_o <= 1'b0;
          if (result_kind_o == KindCoef) begin
            if (last_result_o) state_q <= StLoad;
            else begin
              res_valid_o <= 1'b1;
              row_index_o <= row_index_o + 3'd1;
              result_value_o <= coef_q[row_index_o + 3'd1];
              last_result_o <= (row_index_o + 3'd2 == n);
            end
          end else if (j_q == n - 3'd1 && i_q == n - 3'd1) begin
            res_valid_o <= 1'b1;
            result_kind_o <= KindCoef;
            row_index_o <= '0; col_index_o <= '0;
            result_value_o <= coef_q[0];
            last_result_o <= (n == 3'd1);
          end else begin
            if (j_q == n - 3'd1) begin
              j_q <= '0; i_q <= i_q + 3'd1;
            end else j_q <= j_q + 3'd1;
            state_q <= StOutRd;
          end
        end
        default: state_q <= StLoad;
      endcase
      // The high half is formed while the low half is added.
      if (lo_v_q) begin
        prod_q <= {pp_hi, 32'd0};
        hi_v_q <= 1'b1;
      end
      if (lo_v_q || hi_v_q) acc_q <= acc_q + 128'(prod_q);
    end
  end
endmodule

@@ sv/fli_checker.sv @@
// Port-level checker for the Faddeev-LeVerrier block, bound to the top level.
module fli_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic elem_stall_o,
  input logic res_valid_o,
  input logic res_stall_i,
  input logic result_kind_o,
  input logic last_result_o,
  input logic singular_flag_o
);
  // A last result is always a coefficient.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_result_o |-> result_kind_o)
    else $error("last result is not a coefficient");
  // No element is taken while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> elem_stall_o)
    else $error("input open during output");
  // A stalled result keeps valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o)
    else $error("result dropped under stall");
  // Singular flag is steady across a run of coefficients.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && result_kind_o && !res_stall_i && !last_result_o |=>
      $stable(singular_flag_o))
    else $error("singular flag changed within run");
endmodule

bind faddeev_leverrier_inverse fli_checker u_fli_checker (.*);
